// ===== rtl/core/step_timing_ring_buffer_macros.svh =====
// Assertion macros used by the step timing ring buffer checker.
`ifndef STEP_TIMING_RING_BUFFER_MACROS_SVH
`define STEP_TIMING_RING_BUFFER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define STB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define STB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked during reset.
`define STB_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/stb_pkg.sv =====
// Package with the types, codes and constants of the step timing ring buffer.
`timescale 1ns / 1ps

package stb_pkg;

  // Default number of slots in the ring.
  localparam int DEPTH_DEFAULT = 16;

  // Field widths.
  localparam int OP_W       = 2;
  localparam int TIME_W     = 32;
  localparam int SIG_W      = 16;
  localparam int LEVEL_W    = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_INIT  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_TOTAL = 1'b1;

  // Configuration reset values.
  localparam logic [LEVEL_W-1:0] MIN_LEVEL_RST = 5'd4;
  localparam logic [TIME_W-1:0]  MIN_TOTAL_RST = 32'd10000;

  // Marker returned by a read of an empty ring.
  localparam logic [TIME_W-1:0] EMPTY_MARK = 32'd1000;

  // The delay is stored this many slots before the tail.
  localparam int DELAY_LEAD = 2;

  // One input item.
  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [TIME_W-1:0] step_time;
    logic [SIG_W-1:0]  step_signals;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [TIME_W-1:0]  out_time;
    logic [SIG_W-1:0]   out_signals;
    logic               done_res;
    logic [LEVEL_W-1:0] fill_level;
    logic [TIME_W-1:0]  total_ticks;
    logic               needs_filling;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_step;
    logic init_start;
    logic accept;
    logic fill_push;
    logic finish;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic div_busy;
    logic fill_more;
  } dp_status_t;

endpackage

// ===== rtl/core/stb_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module stb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/stb_div.sv =====
// Restoring divider that forms the default prefill delay one bit per cycle.
`timescale 1ns / 1ps

module stb_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [stb_pkg::TIME_W-1:0]  dividend,
  input  logic [stb_pkg::LEVEL_W-1:0] divisor,
  output logic                        busy,
  output logic [stb_pkg::TIME_W-1:0]  quotient
);

  import stb_pkg::*;

  localparam int STEP_W = $clog2(TIME_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TIME_W - 1);

  logic [TIME_W-1:0]  quo_r;
  logic [LEVEL_W-1:0] rem_r;
  logic [LEVEL_W-1:0] rem_nxt;
  logic [LEVEL_W:0]   rem_sh;
  logic [LEVEL_W:0]   rem_diff;
  logic               take;
  logic [STEP_W-1:0]  step_r;
  logic               busy_r;

  // One restoring step. A zero divisor always subtracts, so the quotient
  // comes out as all ones.
  always_comb begin
    rem_sh   = {rem_r, quo_r[TIME_W-1]};
    take     = (rem_sh >= {1'b0, divisor});
    rem_diff = rem_sh - {1'b0, divisor};
    rem_nxt  = take ? rem_diff[LEVEL_W-1:0] : rem_sh[LEVEL_W-1:0];
  end

  // Step counter and busy flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= LAST_STEP;
    end else if (busy_r) begin
      step_r <= step_r - 1'b1;
      if (step_r == '0) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Quotient and remainder shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[TIME_W-2:0], take};
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/core/stb_dp.sv =====
// Datapath of the step timing ring buffer: stores, pointers, totals, result register.
`timescale 1ns / 1ps

module stb_dp #(
  parameter int DEPTH = stb_pkg::DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  stb_pkg::in_item_t              in_data,
  input  logic                           cfg_we,
  input  logic [stb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [stb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  stb_pkg::ctrl_cmd_t             cmd,
  output stb_pkg::dp_status_t            status,
  output stb_pkg::out_item_t             out_data
);

  import stb_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT  = AW'(DEPTH - 1);
  localparam logic [AW-1:0] LEAD       = AW'(DELAY_LEAD);
  localparam logic [AW-1:0] LEAD_WRAP  = AW'(DEPTH - DELAY_LEAD);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  // Latched input item.
  logic [OP_W-1:0]    op_r;
  logic [TIME_W-1:0]  time_r;
  logic [SIG_W-1:0]   sig_r;

  // Ring state.
  logic [AW-1:0]      head_r, head_nxt;
  logic [AW-1:0]      tail_r, tail_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [TIME_W-1:0]  sum_r, sum_nxt;
  logic [AW-1:0]      clr_addr_r;

  // Configuration registers.
  logic [LEVEL_W-1:0] min_level_r;
  logic [TIME_W-1:0]  min_total_r;

  // Result register and its next value.
  out_item_t          out_r;
  logic [TIME_W-1:0]  res_time;
  logic [SIG_W-1:0]   res_sig;
  logic               res_done;

  // Store ports.
  logic               full, empty, push_we;
  logic [AW-1:0]      lead_slot;
  logic               dly_we, sig_we, rd_en;
  logic [AW-1:0]      dly_waddr, sig_waddr;
  logic [TIME_W-1:0]  dly_wdata, rd_delay;
  logic [SIG_W-1:0]   sig_wdata, rd_sig;

  // Default delay from the divider.
  logic [TIME_W-1:0]  dflt;
  logic               div_busy;

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  function automatic logic fill_needed(input logic [CW-1:0]      cnt,
                                       input logic [TIME_W-1:0]  sum,
                                       input logic [LEVEL_W-1:0] lvl,
                                       input logic [TIME_W-1:0]  tot);
    return (32'(cnt) < 32'(lvl)) || (sum < tot);
  endfunction

  // Ring occupancy and the slot that takes a new delay.
  always_comb begin
    full      = (count_r == FULL_COUNT);
    empty     = (count_r == '0);
    lead_slot = (tail_r >= LEAD) ? tail_r - LEAD : tail_r + LEAD_WRAP;
  end

  // Next ring state for initialize, prefill and the finish of an item.
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    sum_nxt   = sum_r;
    res_time  = '0;
    res_sig   = '0;
    res_done  = 1'b0;
    push_we   = 1'b0;
    if (cmd.init_start) begin
      head_nxt  = '0;
      tail_nxt  = '0;
      count_nxt = '0;
      sum_nxt   = '0;
    end else if (cmd.fill_push) begin
      tail_nxt  = slot_inc(tail_r);
      count_nxt = count_r + 1'b1;
      sum_nxt   = sum_r + dflt;
    end else if (cmd.finish) begin
      unique case (op_r)
        OP_WRITE: begin
          if (!full) begin
            push_we   = 1'b1;
            tail_nxt  = slot_inc(tail_r);
            count_nxt = count_r + 1'b1;
            sum_nxt   = sum_r + time_r;
            res_done  = 1'b1;
          end
        end
        OP_READ: begin
          if (!empty) begin
            res_time  = rd_delay;
            res_sig   = rd_sig;
            sum_nxt   = sum_r - rd_delay;
            head_nxt  = slot_inc(head_r);
            count_nxt = count_r - 1'b1;
            res_done  = 1'b1;
          end else begin
            res_time = EMPTY_MARK;
            res_sig  = SIG_W'(EMPTY_MARK);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Store write and read ports. The clearing pass writes zeros to both.
  always_comb begin
    dly_we    = cmd.clear_step | cmd.fill_push | push_we;
    dly_waddr = cmd.clear_step ? clr_addr_r : lead_slot;
    dly_wdata = cmd.clear_step ? '0 : (cmd.fill_push ? dflt : time_r);
    sig_we    = dly_we;
    sig_waddr = cmd.clear_step ? clr_addr_r : tail_r;
    sig_wdata = (cmd.clear_step | cmd.fill_push) ? '0 : sig_r;
    rd_en     = cmd.accept && (in_data.operation == OP_READ);
  end

  stb_ram #(
    .WIDTH (TIME_W),
    .DEPTH (DEPTH)
  ) u_delay_ram (
    .clk   (clk),
    .we    (dly_we),
    .waddr (dly_waddr),
    .wdata (dly_wdata),
    .re    (rd_en),
    .raddr (head_r),
    .rdata (rd_delay)
  );

  stb_ram #(
    .WIDTH (SIG_W),
    .DEPTH (DEPTH)
  ) u_signal_ram (
    .clk   (clk),
    .we    (sig_we),
    .waddr (sig_waddr),
    .wdata (sig_wdata),
    .re    (rd_en),
    .raddr (head_r),
    .rdata (rd_sig)
  );

  stb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.init_start),
    .dividend (min_total_r),
    .divisor  (min_level_r),
    .busy     (div_busy),
    .quotient (dflt)
  );

  // Ring state, clearing address and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      sum_r       <= '0;
      clr_addr_r  <= '0;
      min_level_r <= MIN_LEVEL_RST;
      min_total_r <= MIN_TOTAL_RST;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      if (cmd.clear_step) begin
        clr_addr_r <= slot_inc(clr_addr_r);
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MIN_LEVEL: min_level_r <= cfg_wdata[LEVEL_W-1:0];
          CFG_MIN_TOTAL: min_total_r <= cfg_wdata[TIME_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Input item latch and result register.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= in_data.operation;
      time_r <= in_data.step_time;
      sig_r  <= in_data.step_signals;
    end
    if (cmd.finish) begin
      out_r.out_time      <= res_time;
      out_r.out_signals   <= res_sig;
      out_r.done_res      <= res_done;
      out_r.fill_level    <= LEVEL_W'(count_nxt);
      out_r.total_ticks   <= sum_nxt;
      out_r.needs_filling <= fill_needed(count_nxt, sum_nxt, min_level_r, min_total_r);
    end
  end

  // Status back to the controller.
  always_comb begin
    status.clear_last = (clr_addr_r == LAST_SLOT);
    status.div_busy   = div_busy;
    status.fill_more  = fill_needed(count_r, sum_r, min_level_r, min_total_r) && !full;
  end

  assign out_data = out_r;

endmodule

// ===== rtl/core/stb_ctrl.sv =====
// Controller of the step timing ring buffer: sequences clearing, prefill and items.
`timescale 1ns / 1ps

module stb_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [stb_pkg::OP_W-1:0] in_op,
  output logic                     out_valid,
  input  logic                     out_ready,
  output stb_pkg::ctrl_cmd_t       cmd,
  input  stb_pkg::dp_status_t      status
);

  import stb_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_FILL  = 3'd2;
  localparam logic [2:0] ST_IDLE  = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       boot_r, boot_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    boot_nxt      = boot_r;
    cmd           = '0;
    out_free      = !out_valid_r || out_ready;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          cmd.init_start = 1'b1;
          state_nxt      = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!status.div_busy) begin
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        if (status.fill_more) begin
          cmd.fill_push = 1'b1;
        end else if (boot_r) begin
          // The prefill after reset gives no result item.
          boot_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_op == OP_INIT) begin
            cmd.init_start = 1'b1;
            state_nxt      = ST_DIV;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      boot_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      boot_r      <= boot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/core/step_timing_ring_buffer.sv =====
// Top level of the step timing ring buffer.
// A ring FIFO of motor step items with a running tick total. Each accepted
// item gives exactly one result item from an output register, and the next
// item is taken while that result still waits. A write, a read or a no-op
// is accepted in ST_IDLE, in which a read issues its registered store read,
// and finished in ST_FIN, which updates the pointers, level and total once
// the output register is free. An initialize runs the bit-serial divider
// that forms the default delay, then the prefill writes one item per cycle.
// After reset the block first clears both stores, one slot per cycle, then
// runs the same prefill with the reset register values; no item is
// accepted and no result is given until that is done.
// Configuration writes are taken at any time.
`timescale 1ns / 1ps

module step_timing_ring_buffer #(
  parameter int DEPTH = stb_pkg::DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  stb_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output stb_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [stb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [stb_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import stb_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer.
  stb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_data.operation),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  // Stores, counters and result register.
  stb_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/core/stb_checker.sv =====
// Port-level checker of the step timing ring buffer and its bind statement.
`timescale 1ns / 1ps
`include "step_timing_ring_buffer_macros.svh"

module stb_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input stb_pkg::out_item_t out_data
);

  import stb_pkg::*;

  // A result that is not taken stays and holds its value.
  `STB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  // The clearing pass after reset takes no item.
  `STB_ASSERT_NEXT_ALWAYS(a_reset_busy, !rst_n, !in_ready, "item taken during the clearing pass")

  // An item that is taken is still worked on in the cycle after, so no new item is taken then.
  `STB_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready, "item taken on back-to-back cycles")

  // A result that did nothing but carries a delay is an empty read.
  `STB_ASSERT_IMP(a_empty_read, out_valid && !out_data.done_res && (out_data.out_time != '0), (out_data.out_signals == SIG_W'(EMPTY_MARK)) && (out_data.fill_level == '0), "bad empty read result")

endmodule

bind step_timing_ring_buffer stb_checker u_stb_checker (.*);
